FILE: hw/rtl/dnes_pkg.sv
package dnes_pkg;

  localparam int CHAR_BITS = 8;
  localparam logic [CHAR_BITS-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_BITS-1:0] CHAR_NINE = 8'h39;

  // A decimal digit and the headroom that one step of value * 10 + digit needs.
  localparam int DIGIT_BITS = 4;
  localparam int RADIX = 10;

  typedef logic [CHAR_BITS-1:0] char_t;
  typedef logic [DIGIT_BITS-1:0] digit_t;

endpackage

FILE: hw/rtl/dnes_accum.sv
module dnes_accum #(
  parameter int VALUE_BITS = 31
) (
  input  dnes_pkg::char_t        char_code,
  input  logic [VALUE_BITS-1:0]  acc,
  output logic                   is_digit,
  output logic [VALUE_BITS-1:0]  acc_next
);
  import dnes_pkg::*;

  localparam int WIDE_BITS = VALUE_BITS + DIGIT_BITS;
  localparam logic [WIDE_BITS-1:0] MAX_WIDE = {{DIGIT_BITS{1'b0}}, {VALUE_BITS{1'b1}}};

  digit_t                 digit;
  logic [WIDE_BITS-1:0]   acc_wide;
  logic [WIDE_BITS-1:0]   sum;
  char_t                  offset;

  assign is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
  assign offset   = char_code - CHAR_ZERO;
  assign digit    = offset[DIGIT_BITS-1:0];
  assign acc_wide = {{DIGIT_BITS{1'b0}}, acc};

  // acc * 10 as two shifts; acc never exceeds the maximum, so the sum fits.
  assign sum = (acc_wide << 3) + (acc_wide << 1) + {{(WIDE_BITS-DIGIT_BITS){1'b0}}, digit};

  always_comb begin
    if (sum > MAX_WIDE) begin
      acc_next = {VALUE_BITS{1'b1}};
    end else begin
      acc_next = sum[VALUE_BITS-1:0];
    end
  end

endmodule

FILE: hw/rtl/decimal_number_extract_and_sort.sv
// Decimal number extraction with ascending sort.
// Characters of a line enter on the char channel (char_code, end_of_line),
// one transaction per cycle while char_stall is low. Each run of ASCII
// digits becomes a number, saturated at 2^VALUE_BITS - 1; up to CAPACITY
// numbers per line are kept in a single dual-port RAM, later ones dropped.
// The transaction with end_of_line set closes the line. char_stall then
// stays high while the RAM is insertion-sorted in place: every element
// after the first is read from the RAM, loaded, compared and moved down one
// position at a time past each larger predecessor, then written into place.
// Results then leave on the result channel in ascending order, each one
// read from the RAM and then presented, with last_value on the final one.
// A line without numbers gives one result with no_numbers set and value 0.
// While result_stall is high the result holds and nothing else moves; the
// next line is accepted after the last result transaction.
// rst (synchronous) empties the store and returns to accepting characters;
// the RAM needs no clearing since only written entries are read.
module decimal_number_extract_and_sort #(
  parameter int CAPACITY   = 64,
  parameter int VALUE_BITS = 31
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  char_valid,
  output logic                  char_stall,
  input  dnes_pkg::char_t       char_code,
  input  logic                  end_of_line,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [VALUE_BITS-1:0] sorted_value,
  output logic                  last_value,
  output logic                  no_numbers
);
  import dnes_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] S_IN    = 3'd0;
  localparam logic [2:0] S_RDV   = 3'd1;
  localparam logic [2:0] S_GETV  = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_PLACE = 3'd4;
  localparam logic [2:0] S_ORD   = 3'd5;
  localparam logic [2:0] S_OSEND = 3'd6;
  localparam logic [2:0] S_EMPTY = 3'd7;

  logic [VALUE_BITS-1:0] mem [CAPACITY];
  logic [VALUE_BITS-1:0] rdata;

  logic [2:0]            state;
  logic [2:0]            state_next;
  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  logic [VALUE_BITS-1:0] acc;
  logic                  in_number;
  logic [IW-1:0]         i;
  logic [IW-1:0]         j;
  logic [IW-1:0]         k;
  logic [VALUE_BITS-1:0] v;

  logic                  is_digit;
  logic [VALUE_BITS-1:0] acc_step;
  logic                  char_accept;
  logic                  finish;
  logic [VALUE_BITS-1:0] finish_value;
  logic                  store_write;
  logic                  we;
  logic [IW-1:0]         waddr;
  logic [VALUE_BITS-1:0] wdata;
  logic                  ren;
  logic [IW-1:0]         raddr;
  logic                  shift;
  logic                  i_last;
  logic                  k_last;

  dnes_accum #(
    .VALUE_BITS(VALUE_BITS)
  ) u_accum (
    .char_code(char_code),
    .acc      (acc),
    .is_digit (is_digit),
    .acc_next (acc_step)
  );

  assign char_stall  = (state != S_IN);
  assign char_accept = char_valid && (state == S_IN);

  // A non-digit closes the pending run; a digit with end of line closes the
  // run that includes it.
  assign finish       = is_digit ? end_of_line : in_number;
  assign finish_value = is_digit ? acc_step : acc;
  assign store_write  = char_accept && finish && (count < CW'(CAPACITY));
  assign count_next   = count + {{(CW-1){1'b0}}, store_write};

  assign shift  = (rdata > v);
  assign i_last = (CW'(i) == count - CW'(1));
  assign k_last = (CW'(k) == count - CW'(1));

  always_comb begin
    we    = 1'b0;
    waddr = j;
    wdata = v;
    ren   = 1'b0;
    raddr = k;
    case (state)
      S_IN: begin
        we    = store_write;
        waddr = count[IW-1:0];
        wdata = finish_value;
      end
      S_RDV: begin
        ren   = 1'b1;
        raddr = i;
      end
      S_GETV: begin
        ren   = 1'b1;
        raddr = i - IW'(1);
      end
      S_CMP: begin
        we    = 1'b1;
        waddr = j;
        wdata = shift ? rdata : v;
        ren   = shift && (j > IW'(1));
        raddr = j - IW'(2);
      end
      S_PLACE: begin
        we    = 1'b1;
        waddr = '0;
        wdata = v;
      end
      S_ORD: begin
        ren   = 1'b1;
        raddr = k;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IN: begin
        if (char_accept && end_of_line) begin
          if (count_next == '0) begin
            state_next = S_EMPTY;
          end else if (count_next == CW'(1)) begin
            state_next = S_ORD;
          end else begin
            state_next = S_RDV;
          end
        end
      end
      S_RDV:  state_next = S_GETV;
      S_GETV: state_next = S_CMP;
      S_CMP: begin
        if (shift) begin
          if (j == IW'(1)) begin
            state_next = S_PLACE;
          end
        end else begin
          state_next = i_last ? S_ORD : S_RDV;
        end
      end
      S_PLACE: state_next = i_last ? S_ORD : S_RDV;
      S_ORD:   state_next = S_OSEND;
      S_OSEND: begin
        if (!result_stall) begin
          state_next = k_last ? S_IN : S_ORD;
        end
      end
      S_EMPTY: begin
        if (!result_stall) begin
          state_next = S_IN;
        end
      end
      default: state_next = S_IN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IN;
      count     <= '0;
      acc       <= '0;
      in_number <= 1'b0;
      i         <= '0;
      j         <= '0;
      k         <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IN: begin
          if (char_accept) begin
            count <= count_next;
            if (is_digit && !end_of_line) begin
              acc       <= acc_step;
              in_number <= 1'b1;
            end else begin
              acc       <= '0;
              in_number <= 1'b0;
            end
            i <= IW'(1);
            k <= '0;
          end
        end
        S_GETV: begin
          j <= i;
        end
        S_CMP: begin
          if (shift) begin
            j <= j - IW'(1);
          end else if (!i_last) begin
            i <= i + IW'(1);
          end
        end
        S_PLACE: begin
          if (!i_last) begin
            i <= i + IW'(1);
          end
        end
        S_OSEND: begin
          if (!result_stall) begin
            if (k_last) begin
              count <= '0;
            end else begin
              k <= k + IW'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // The element being inserted is captured as it comes out of the RAM.
  always_ff @(posedge clk) begin
    if (state == S_GETV) begin
      v <= rdata;
    end
  end

  assign result_valid = (state == S_OSEND) || (state == S_EMPTY);
  assign no_numbers   = (state == S_EMPTY);
  assign sorted_value = (state == S_EMPTY) ? '0 : rdata;
  assign last_value   = (state == S_EMPTY) || k_last;

endmodule

FILE: tb/sv/tb_decimal_number_extract_and_sort.sv
module tb_decimal_number_extract_and_sort;
  import dnes_pkg::*;

  localparam int CAPACITY = 64;
  localparam int VALUE_BITS = 31;
  localparam logic [VALUE_BITS-1:0] MAX_VALUE = {VALUE_BITS{1'b1}};
  localparam int ITEM_TARGET = 450;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 20000;
  localparam int PRINT_LIMIT = 100;

  typedef logic [VALUE_BITS-1:0] value_t;

  typedef struct packed {
    value_t value;
    logic   last;
    logic   none;
  } sorted_result_t;

  typedef struct packed {
    char_t          code;
    logic           eol;
    logic           typed;
    sorted_result_t result;
  } char_row_t;

  logic   clk;
  logic   rst = 1'b1;
  logic   char_valid = 1'b0;
  logic   char_stall;
  char_t  char_code = '0;
  logic   end_of_line = 1'b0;
  logic   result_valid;
  logic   result_stall = 1'b0;
  value_t sorted_value;
  logic   last_value;
  logic   no_numbers;

  // Expected results still to come from lines accepted so far, oldest first.
  sorted_result_t pending_results[$];
  char_row_t      char_rows[$];

  // Shadow of the block: numbers of the current line and the run in progress.
  value_t line_numbers[$];
  value_t run_value = '0;
  logic   in_run = 1'b0;

  int  mismatches = 0;
  int  items_sent = 0;
  int  sender_idle_pct = 0;
  int  receiver_stall_pct = 0;
  logic hold_request = 1'b0;

  decimal_number_extract_and_sort #(
    .CAPACITY  (CAPACITY),
    .VALUE_BITS(VALUE_BITS)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .char_valid  (char_valid),
    .char_stall  (char_stall),
    .char_code   (char_code),
    .end_of_line (end_of_line),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .sorted_value(sorted_value),
    .last_value  (last_value),
    .no_numbers  (no_numbers)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input longint unsigned want,
                                 input longint unsigned got);
    if (mismatches < PRINT_LIMIT) begin
      $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
    end
    mismatches++;
  endtask

  function automatic logic is_digit(input char_t c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic void close_run();
    if (in_run && line_numbers.size() < CAPACITY) begin
      line_numbers.push_back(run_value);
    end
    in_run = 1'b0;
    run_value = '0;
  endfunction

  // Advances the shadow by one character; at end of line it sorts the kept
  // numbers and queues them as expected results when queue_results is set.
  function automatic void take_char(input char_t c, input logic eol,
                                    input logic queue_results);
    logic [63:0] grown;
    value_t held;
    int j;
    sorted_result_t res;
    if (is_digit(c)) begin
      grown = 64'(run_value) * 64'd10 + 64'(c - CHAR_ZERO);
      run_value = (grown > 64'(MAX_VALUE)) ? MAX_VALUE : grown[VALUE_BITS-1:0];
      in_run = 1'b1;
    end else begin
      close_run();
    end
    if (eol) begin
      close_run();
      for (int i = 1; i < line_numbers.size(); i++) begin
        held = line_numbers[i];
        j = i;
        while (j > 0 && line_numbers[j-1] > held) begin
          line_numbers[j] = line_numbers[j-1];
          j--;
        end
        line_numbers[j] = held;
      end
      if (queue_results) begin
        if (line_numbers.size() == 0) begin
          res = '{value: '0, last: 1'b1, none: 1'b1};
          pending_results.push_back(res);
        end
        for (int k = 0; k < line_numbers.size(); k++) begin
          res = '{value: line_numbers[k], last: (k == line_numbers.size() - 1), none: 1'b0};
          pending_results.push_back(res);
        end
      end
      line_numbers.delete();
      run_value = '0;
      in_run = 1'b0;
    end
  endfunction

  task automatic add_row(input char_t c, input logic eol, input logic typed,
                         input value_t value, input logic last, input logic none);
    char_rows.push_back('{code: c, eol: eol, typed: typed,
                          result: '{value: value, last: last, none: none}});
  endtask

  task automatic set_idling(input int phase);
    case (phase)
      0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
      1: begin sender_idle_pct = 58; receiver_stall_pct = 0;  end
      2: begin sender_idle_pct = 0;  receiver_stall_pct = 58; end
      default: begin sender_idle_pct = 6; receiver_stall_pct = 6; end
    endcase
  endtask

  // Presents one character and returns at the edge that takes the transaction.
  task automatic offer_char(input char_t c, input logic eol);
    while ($urandom_range(99) < sender_idle_pct) begin
      char_valid <= 1'b0;
      @(posedge clk);
    end
    char_valid <= 1'b1;
    char_code <= c;
    end_of_line <= eol;
    @(posedge clk);
    while (char_stall) @(posedge clk);
    items_sent++;
  endtask

  function automatic char_t any_separator();
    char_t c;
    c = char_t'($urandom_range(255));
    while (is_digit(c)) c = char_t'($urandom_range(255));
    return c;
  endfunction

  function automatic char_t any_digit();
    return CHAR_ZERO + char_t'($urandom_range(9));
  endfunction

  task automatic send_line(input char_t chars[$]);
    for (int i = 0; i < chars.size(); i++) begin
      offer_char(chars[i], i == chars.size() - 1);
      take_char(chars[i], i == chars.size() - 1, 1'b1);
    end
  endtask

  // Builds one line: numbers with random separators, a noisy line, a line of one
  // separator, or a line with at least as many numbers as the store keeps.
  task automatic random_line(input logic overfill);
    char_t chars[$];
    int kind;
    int count;
    int width;
    kind = $urandom_range(99);
    if (overfill) begin
      count = $urandom_range(CAPACITY + 6, CAPACITY);
      for (int n = 0; n < count; n++) begin
        chars.push_back(any_digit());
        chars.push_back(any_separator());
      end
    end else if (kind < 70) begin
      count = $urandom_range(8, 1);
      for (int n = 0; n < count; n++) begin
        width = ($urandom_range(9) == 0) ? $urandom_range(12, 10) : $urandom_range(4, 1);
        for (int d = 0; d < width; d++) chars.push_back(any_digit());
        if (n != count - 1 || $urandom_range(1)) chars.push_back(any_separator());
      end
    end else if (kind < 90) begin
      count = $urandom_range(10, 1);
      for (int n = 0; n < count; n++) chars.push_back(char_t'($urandom_range(255)));
    end else begin
      chars.push_back(any_separator());
    end
    send_line(chars);
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request <= 1'b0;
        result_stall <= 1'b0;
      end else begin
        result_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    sorted_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, value", 0, sorted_value);
      end else begin
        want = pending_results.pop_front();
        if (sorted_value !== want.value) report_mismatch("sorted_value", want.value, sorted_value);
        if (last_value !== want.last) report_mismatch("last_value", want.last, last_value);
        if (no_numbers !== want.none) report_mismatch("no_numbers", want.none, no_numbers);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((char_valid && !char_stall) || (result_valid && !result_stall)) quiet = 0;
      else quiet++;
    end
    $display("decimal_number_extract_and_sort: mismatch");
    $finish;
  end

  initial begin
    int line_index;
    // A line without numbers right after reset.
    add_row(8'h20, 1'b1, 1'b1, '0, 1'b1, 1'b1);
    // Ten nines saturate at the largest value.
    for (int i = 0; i < 9; i++) add_row(CHAR_NINE, 1'b0, 1'b0, '0, 1'b0, 1'b0);
    add_row(CHAR_NINE, 1'b1, 1'b1, MAX_VALUE, 1'b1, 1'b0);
    // Byte extremes and the neighbors of the digit range as separators,
    // two equal values, and end of line on a digit.
    add_row(8'h00, 1'b0, 1'b0, '0, 1'b0, 1'b0);
    add_row(CHAR_ZERO, 1'b0, 1'b0, '0, 1'b0, 1'b0);
    add_row(CHAR_ZERO - 8'd1, 1'b0, 1'b0, '0, 1'b0, 1'b0);
    add_row(CHAR_NINE, 1'b0, 1'b0, '0, 1'b0, 1'b0);
    add_row(CHAR_NINE + 8'd1, 1'b0, 1'b0, '0, 1'b0, 1'b0);
    add_row(8'hFF, 1'b0, 1'b0, '0, 1'b0, 1'b0);
    add_row(CHAR_NINE, 1'b1, 1'b0, '0, 1'b0, 1'b0);
    add_row(CHAR_ZERO, 1'b1, 1'b1, '0, 1'b1, 1'b0);
    add_row(8'hFF, 1'b1, 1'b1, '0, 1'b1, 1'b1);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    set_idling(0);

    foreach (char_rows[i]) begin
      offer_char(char_rows[i].code, char_rows[i].eol);
      take_char(char_rows[i].code, char_rows[i].eol, !char_rows[i].typed);
      if (char_rows[i].typed) pending_results.push_back(char_rows[i].result);
    end

    line_index = 0;
    while (items_sent < ITEM_TARGET) begin
      set_idling((line_index / 6) % 4);
      if (line_index >= 5 && line_index < 9) begin
        // Keep offering lines while the result side is held off.
        set_idling(0);
        if (line_index == 5) hold_request <= 1'b1;
      end
      random_line(line_index == 14);
      line_index++;
    end
    char_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("decimal_number_extract_and_sort: match");
    end else begin
      $display("decimal_number_extract_and_sort: mismatch");
    end
    $finish;
  end

endmodule

FILE: decimal_number_extract_and_sort.f
hw/rtl/dnes_pkg.sv
hw/rtl/dnes_accum.sv
hw/rtl/decimal_number_extract_and_sort.sv
tb/sv/tb_decimal_number_extract_and_sort.sv
